@@ hw/rtl/aes_pkg.sv @@
`default_nettype none
package aes_pkg;

   localparam int Rounds   = 10;
   localparam int RoundW   = $clog2(Rounds + 1);

   localparam logic [2:0] CSR_KEY_HIGH = 3'd0;
   localparam logic [2:0] CSR_KEY_LOW  = 3'd1;
   localparam logic [2:0] CSR_IV_HIGH  = 3'd2;
   localparam logic [2:0] CSR_IV_LOW   = 3'd3;
   localparam logic [2:0] CSR_DECRYPT  = 3'd4;

   typedef struct packed {
      logic [63:0] block_high;
      logic [63:0] block_low;
      logic        first_block;
   } req_type;

   typedef struct packed {
      logic [63:0] result_high;
      logic [63:0] result_low;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_EXPAND, ST_LOAD, ST_ROUND, ST_DONE
   } state_type;

   typedef struct packed {
      logic             start;
      logic             expand;
      logic             load;
      logic             round;
      logic             finish;
      logic [RoundW-1:0] rnd;
   } cmd_type;

   typedef logic [7:0] sbox_table_type [256];

   localparam sbox_table_type Sbox = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] inv_sbox(input logic [7:0] v);
      logic [7:0] r;
      r = 8'h00;
      for (int i = 0; i < 256; i++) begin
         if (Sbox[i] == v) r = 8'(i);
      end
      return r;
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] rcon(input logic [RoundW-1:0] r);
      logic [7:0] v;
      v = 8'h01;
      for (int i = 1; i < Rounds; i++) begin
         if (r > RoundW'(i)) v = xtime(v);
      end
      return v;
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/aes_ram.sv @@
`default_nettype none
module aes_ram #(
   parameter int Width = 64,
   parameter int Depth = 22
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output      logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

@@ hw/rtl/aes_ctrl.sv @@
`default_nettype none
module aes_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_ready,
   input  wire logic                       first_block,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   output      aes_pkg::cmd_type           cmd
);
   aes_pkg::state_type state_ff, state_in;
   logic [aes_pkg::RoundW-1:0] rnd_ff, rnd_in;
   logic rsp_valid_ff, rsp_valid_in;

   // expansion: rnd steps 0..Rounds, one round key (two entries) a step
   // load: reads round key for first round. round: rnd 1..Rounds
   // done: holds until the response register is free
   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      unique case (state_ff)
         aes_pkg::ST_IDLE: begin
            if (req_valid && req_ready) begin
               rnd_in   = '0;
               state_in = first_block ? aes_pkg::ST_EXPAND : aes_pkg::ST_LOAD;
            end
         end
         aes_pkg::ST_EXPAND: begin
            rnd_in = rnd_ff + 1'b1;
            if (rnd_ff == aes_pkg::RoundW'(aes_pkg::Rounds)) begin
               rnd_in   = '0;
               state_in = aes_pkg::ST_LOAD;
            end
         end
         aes_pkg::ST_LOAD: begin
            rnd_in   = aes_pkg::RoundW'(1);
            state_in = aes_pkg::ST_ROUND;
         end
         aes_pkg::ST_ROUND: begin
            rnd_in = rnd_ff + 1'b1;
            if (rnd_ff == aes_pkg::RoundW'(aes_pkg::Rounds)) state_in = aes_pkg::ST_DONE;
         end
         aes_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = aes_pkg::ST_IDLE;
         end
         default: state_in = aes_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.finish) rsp_valid_in = 1'b1;
   end

   always_comb begin
      cmd        = '0;
      cmd.rnd    = rnd_ff;
      req_ready  = (state_ff == aes_pkg::ST_IDLE);
      cmd.start  = req_valid && req_ready;
      cmd.expand = (state_ff == aes_pkg::ST_EXPAND);
      cmd.load   = (state_ff == aes_pkg::ST_LOAD);
      cmd.round  = (state_ff == aes_pkg::ST_ROUND);
      cmd.finish = (state_ff == aes_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);
      rsp_valid  = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aes_pkg::ST_IDLE;
         rnd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rnd_ff       <= rnd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

@@ hw/rtl/aes_datapath.sv @@
`default_nettype none
module aes_datapath (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire aes_pkg::cmd_type cmd,
   input  wire aes_pkg::req_type req,
   input  wire logic             csr_valid,
   input  wire logic [2:0]       csr_index,
   input  wire logic [63:0]      csr_data,
   output      aes_pkg::rsp_type rsp
);
   logic [63:0] key_hi_ff, key_lo_ff, iv_hi_ff, iv_lo_ff;
   logic        dec_ff;
   logic [127:0] chain_ff, chain_in, st_ff, st_in, wk_ff, wk_in, in_ff, out_ff;
   logic [127:0] rk, nk;
   logic [63:0]  rd_data;

   logic                       wr_en;
   logic [aes_pkg::RoundW-1:0] wr_addr, rd_addr;
   logic [63:0]                wr_data, wr_data_lo;

   // round keys held as high and low halves in two RAMs read at one address
   logic [63:0] rd_lo;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff <= '0; key_lo_ff <= '0; iv_hi_ff <= '0; iv_lo_ff <= '0; dec_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            aes_pkg::CSR_KEY_HIGH: key_hi_ff <= csr_data;
            aes_pkg::CSR_KEY_LOW:  key_lo_ff <= csr_data;
            aes_pkg::CSR_IV_HIGH:  iv_hi_ff  <= csr_data;
            aes_pkg::CSR_IV_LOW:   iv_lo_ff  <= csr_data;
            aes_pkg::CSR_DECRYPT:  dec_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   // key expansion, one round key per step
   function automatic logic [127:0] next_key(input logic [127:0] k,
                                            input logic [aes_pkg::RoundW-1:0] r);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
      t  = {aes_pkg::Sbox[w3[23:16]] ^ aes_pkg::rcon(r), aes_pkg::Sbox[w3[15:8]],
            aes_pkg::Sbox[w3[7:0]], aes_pkg::Sbox[w3[31:24]]};
      w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   function automatic logic [31:0] mixcol(input logic [31:0] c);
      logic [7:0] a0, a1, a2, a3, al;
      a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
      al = a0 ^ a1 ^ a2 ^ a3;
      return {a0 ^ al ^ aes_pkg::xtime(a0 ^ a1), a1 ^ al ^ aes_pkg::xtime(a1 ^ a2),
              a2 ^ al ^ aes_pkg::xtime(a2 ^ a3), a3 ^ al ^ aes_pkg::xtime(a3 ^ a0)};
   endfunction

   // InvMixColumns = MixColumns after the 04/05 pre-multiply
   function automatic logic [31:0] invmixcol(input logic [31:0] c);
      logic [7:0] a0, a1, a2, a3, u, v;
      a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
      u = aes_pkg::xtime(aes_pkg::xtime(a0 ^ a2));
      v = aes_pkg::xtime(aes_pkg::xtime(a1 ^ a3));
      return mixcol({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
   endfunction

   function automatic logic [127:0] mix(input logic [127:0] s, input logic inv);
      logic [127:0] o;
      for (int c = 0; c < 4; c++) begin
         o[127-32*c -: 32] = inv ? invmixcol(s[127-32*c -: 32]) : mixcol(s[127-32*c -: 32]);
      end
      return o;
   endfunction

   function automatic logic [127:0] subshift(input logic [127:0] s, input logic inv);
      logic [127:0] o;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (inv)
               o[127-8*(r+4*((c+r)%4)) -: 8] = aes_pkg::inv_sbox(s[127-8*(r+4*c) -: 8]);
            else
               o[127-8*(r+4*c) -: 8] = aes_pkg::Sbox[s[127-8*(r+4*((c+r)%4)) -: 8]];
         end
      end
      return o;
   endfunction

   assign nk         = next_key(wk_ff, cmd.rnd);
   assign wr_en      = cmd.expand;
   assign wr_data    = cmd.rnd == '0 ? key_hi_ff : nk[127:64];
   assign wr_data_lo = cmd.rnd == '0 ? key_lo_ff : nk[63:0];
   assign wr_addr    = cmd.rnd;

   // read address for next cycle's round key
   always_comb begin
      rd_addr = '0;
      if (cmd.load || cmd.round) begin
         if (dec_ff) rd_addr = aes_pkg::RoundW'(aes_pkg::Rounds - 1) - cmd.rnd;
         else        rd_addr = cmd.rnd + 1'b1;
      end else if (dec_ff) begin
         rd_addr = aes_pkg::RoundW'(aes_pkg::Rounds);
      end
   end

   aes_ram #(.Width(64), .Depth(aes_pkg::Rounds + 1)) u_rk_hi (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data);
   aes_ram #(.Width(64), .Depth(aes_pkg::Rounds + 1)) u_rk_lo (
      .clock, .wr_en, .wr_addr, .wr_data(wr_data_lo), .rd_addr, .rd_data(rd_lo));

   assign rk = {rd_data, rd_lo};

   // wk_ff ends each expansion holding the last round key
   always_comb begin
      wk_in = wk_ff;
      if (cmd.expand) wk_in = cmd.rnd == '0 ? {key_hi_ff, key_lo_ff} : nk;
   end

   always_comb begin
      st_in    = st_ff;
      chain_in = chain_ff;
      if (cmd.start && req.first_block) chain_in = {iv_hi_ff, iv_lo_ff};
      if (cmd.load) begin
         st_in = dec_ff ? (in_ff ^ wk_ff) : (in_ff ^ chain_ff ^ rk);
      end
      if (cmd.round) begin
         if (cmd.rnd == aes_pkg::RoundW'(aes_pkg::Rounds))
            st_in = subshift(st_ff, dec_ff) ^ rk;
         else if (dec_ff)
            // InvMix(x) ^ InvMix(k) = InvMix(x ^ k)
            st_in = mix(subshift(st_ff, 1'b1) ^ rk, 1'b1);
         else
            st_in = mix(subshift(st_ff, 1'b0), 1'b0) ^ rk;
      end
      if (cmd.finish) chain_in = dec_ff ? in_ff : st_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= '0;
      end else begin
         chain_ff <= chain_in;
      end
      st_ff <= st_in;
      wk_ff <= wk_in;
      if (cmd.start) in_ff <= {req.block_high, req.block_low};
      if (cmd.finish) out_ff <= dec_ff ? (st_ff ^ chain_ff) : st_ff;
   end

   assign rsp = out_ff;
endmodule
`default_nettype wire

@@ hw/rtl/aes128_cbc_cipher.sv @@
// AES-128 CBC engine. Each request carries one 128-bit block; one response returns
// the enciphered or deciphered block. A request with first_block set first expands
// the key into the round-key RAMs (one round key a cycle) and reloads the chaining
// value from the IV. A taken request passes through the key load, ten rounds of the
// shared round unit and the result register before its response is valid; the next
// request is taken only once the engine is back in idle. A finished
// block waits while the previous response is still unread; the CBC chain holds one
// block in flight. Write key, IV and mode only while idle.
`default_nettype none
module aes128_cbc_cipher (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire aes_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      aes_pkg::rsp_type rsp_data,
   input  wire logic             csr_valid,
   output      logic             csr_ready,
   input  wire logic [2:0]       csr_index,
   input  wire logic [63:0]      csr_data
);
   aes_pkg::cmd_type cmd;

   assign csr_ready = 1'b1;

   aes_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .first_block(req_data.first_block),
      .rsp_valid, .rsp_ready, .cmd);

   aes_datapath u_dp (
      .clock, .reset, .cmd, .req(req_data), .csr_valid, .csr_index, .csr_data,
      .rsp(rsp_data));
endmodule
`default_nettype wire

@@ hw/rtl/aes_checker.sv @@
`default_nettype none
module aes_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire aes_pkg::rsp_type rsp_data
);
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("request taken while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped");
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !(rsp_valid && !$past(rsp_valid)))
      else $error("response too early");
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid) else $error("response after reset");
endmodule

bind aes128_cbc_cipher aes_checker u_chk (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_data);
`default_nettype wire

@@ dv/aes128_cbc_checker.sv @@
module aes128_cbc_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_ready,
   input  wire aes_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_ready,
   input  wire aes_pkg::rsp_type rsp_data,
   input  wire logic             csr_valid,
   input  wire logic             csr_ready,
   input  wire logic [2:0]       csr_index,
   input  wire logic [63:0]      csr_data,
   output int                    fail_count,
   output int                    pending
);

   logic [7:0]   fwd_sb [256];
   logic [7:0]   rev_sb [256];
   logic [127:0] key_reg, iv_reg, chain;
   logic         dec_mode;
   logic [127:0] sched [aes_pkg::Rounds + 1];
   aes_pkg::rsp_type expected_q [$];

   function automatic logic [7:0] dbl(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p = p ^ a;
         a = dbl(a);
      end
      return p;
   endfunction

   // sbox built from the field inverse and the affine map
   initial begin
      logic [7:0] inv, b;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h00;
         for (int y = 1; y < 256; y++) begin
            if (gf_mul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
         end
         b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
             ^ {inv[3:0], inv[7:4]} ^ 8'h63;
         fwd_sb[x] = b;
         rev_sb[b] = 8'(x);
      end
   end

   function automatic logic [7:0] byte_at(input logic [127:0] v, input int i);
      return v[127 - 8 * i -: 8];
   endfunction

   function automatic logic [127:0] sub_shift(input logic [127:0] s);
      logic [127:0] t;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            t[127 - 8 * (r + 4 * c) -: 8] = fwd_sb[byte_at(s, r + 4 * ((c + r) & 3))];
      return t;
   endfunction

   function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
      logic [127:0] t;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            t[127 - 8 * (r + 4 * ((c + r) & 3)) -: 8] = rev_sb[byte_at(s, r + 4 * c)];
      return t;
   endfunction

   function automatic logic [127:0] mix_cols(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0]   a0, a1, a2, a3, all;
      for (int c = 0; c < 4; c++) begin
         a0 = byte_at(s, 4 * c);
         a1 = byte_at(s, 4 * c + 1);
         a2 = byte_at(s, 4 * c + 2);
         a3 = byte_at(s, 4 * c + 3);
         all = a0 ^ a1 ^ a2 ^ a3;
         t[127 - 32 * c -: 32] = {a0 ^ all ^ dbl(a0 ^ a1), a1 ^ all ^ dbl(a1 ^ a2),
                                  a2 ^ all ^ dbl(a2 ^ a3), a3 ^ all ^ dbl(a3 ^ a0)};
      end
      return t;
   endfunction

   function automatic logic [127:0] inv_mix_cols(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0]   a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = byte_at(s, 4 * c);
         a1 = byte_at(s, 4 * c + 1);
         a2 = byte_at(s, 4 * c + 2);
         a3 = byte_at(s, 4 * c + 3);
         t[127 - 32 * c -: 32] = {
            gf_mul(a0, 14) ^ gf_mul(a1, 11) ^ gf_mul(a2, 13) ^ gf_mul(a3, 9),
            gf_mul(a0, 9) ^ gf_mul(a1, 14) ^ gf_mul(a2, 11) ^ gf_mul(a3, 13),
            gf_mul(a0, 13) ^ gf_mul(a1, 9) ^ gf_mul(a2, 14) ^ gf_mul(a3, 11),
            gf_mul(a0, 11) ^ gf_mul(a1, 13) ^ gf_mul(a2, 9) ^ gf_mul(a3, 14)};
      end
      return t;
   endfunction

   task automatic expand_schedule();
      logic [31:0] w [4 * (aes_pkg::Rounds + 1)];
      logic [31:0] t;
      logic [7:0]  rc;
      rc = 8'h01;
      for (int i = 0; i < 4; i++) w[i] = key_reg[127 - 32 * i -: 32];
      for (int i = 4; i < 4 * (aes_pkg::Rounds + 1); i++) begin
         t = w[i - 1];
         if (i % 4 == 0) begin
            t = {fwd_sb[t[23:16]] ^ rc, fwd_sb[t[15:8]], fwd_sb[t[7:0]], fwd_sb[t[31:24]]};
            rc = dbl(rc);
         end
         w[i] = w[i - 4] ^ t;
      end
      for (int r = 0; r <= aes_pkg::Rounds; r++)
         sched[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
   endtask

   function automatic logic [127:0] encipher(input logic [127:0] s);
      s = s ^ sched[0];
      for (int r = 1; r < aes_pkg::Rounds; r++) s = mix_cols(sub_shift(s)) ^ sched[r];
      return sub_shift(s) ^ sched[aes_pkg::Rounds];
   endfunction

   function automatic logic [127:0] decipher(input logic [127:0] s);
      s = s ^ sched[aes_pkg::Rounds];
      for (int r = aes_pkg::Rounds - 1; r >= 1; r--)
         s = inv_mix_cols(inv_sub_shift(s)) ^ inv_mix_cols(sched[r]);
      return inv_sub_shift(s) ^ sched[0];
   endfunction

   always @(posedge clock) begin
      logic [127:0] blk, res;
      aes_pkg::rsp_type exp_rsp;
      if (reset) begin
         key_reg = '0;
         iv_reg = '0;
         dec_mode = 1'b0;
         chain = '0;
         expected_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               aes_pkg::CSR_KEY_HIGH: key_reg[127:64] = csr_data;
               aes_pkg::CSR_KEY_LOW:  key_reg[63:0] = csr_data;
               aes_pkg::CSR_IV_HIGH:  iv_reg[127:64] = csr_data;
               aes_pkg::CSR_IV_LOW:   iv_reg[63:0] = csr_data;
               aes_pkg::CSR_DECRYPT:  dec_mode = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            blk = {req_data.block_high, req_data.block_low};
            if (req_data.first_block) begin
               expand_schedule();
               chain = iv_reg;
            end
            if (dec_mode) begin
               res = decipher(blk) ^ chain;
               chain = blk;
            end else begin
               res = encipher(blk ^ chain);
               chain = res;
            end
            expected_q.push_back({res[127:64], res[63:0]});
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected response %h", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               exp_rsp = expected_q.pop_front();
               if (rsp_data.result_high !== exp_rsp.result_high ||
                   rsp_data.result_low !== exp_rsp.result_low) begin
                  if (fail_count < 10)
                     $display("mismatch: expected %h_%h got %h_%h", exp_rsp.result_high,
                              exp_rsp.result_low, rsp_data.result_high, rsp_data.result_low);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending <= expected_q.size();
   end

endmodule

@@ dv/tb_aes128_cbc_cipher.sv @@
module tb_aes128_cbc_cipher;

   localparam int CycleLimit = 1000000;
   localparam int Settle = 40;
   localparam logic [63:0] Ones = '1;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   aes_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   aes_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [2:0]       csr_index = '0;
   logic [63:0]      csr_data = '0;
   int               fail_count;
   int               pending;
   int               cycles = 0;
   int               burst_left = 0;
   int               stall_mode = 0;

   always #4 clock = ~clock;

   aes128_cbc_cipher dut (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   aes128_cbc_checker checker_i (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data, .fail_count, .pending
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("tb_aes128_cbc_cipher: done, errors");
         $finish;
      end
   end

   // receiver stall pattern, drawn at random from four modes
   always @(posedge clock) begin
      if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(0, 1);
         2: rsp_ready <= ($urandom_range(0, 7) == 0);
         default: rsp_ready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send(input logic [63:0] bh, input logic [63:0] bl, input logic fb);
      req_valid <= 1'b1;
      req_data <= '{block_high: bh, block_low: bl, first_block: fb};
      do @(posedge clock); while (!req_ready);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (Settle) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_all(input logic [63:0] kh, input logic [63:0] kl, input logic [63:0] ih,
                          input logic [63:0] il, input logic dec);
      csr_write(aes_pkg::CSR_KEY_HIGH, kh);
      csr_write(aes_pkg::CSR_KEY_LOW, kl);
      csr_write(aes_pkg::CSR_IV_HIGH, ih);
      csr_write(aes_pkg::CSR_IV_LOW, il);
      csr_write(aes_pkg::CSR_DECRYPT, {63'd0, dec});
   endtask

   initial begin
      int sent, len;
      logic fb;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all-zero and all-one extremes
      set_all('0, '0, '0, '0, 1'b0);
      send('0, '0, 1'b1);
      send(Ones, Ones, 1'b0);
      send(Ones, '0, 1'b1);
      send('0, Ones, 1'b0);
      drain();
      set_all(Ones, Ones, Ones, Ones, 1'b1);
      send('0, '0, 1'b1);
      send(Ones, Ones, 1'b0);
      send(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b0);
      drain();
      // key change mid-message only lands on the next first block
      csr_write(aes_pkg::CSR_KEY_HIGH, rand64());
      csr_write(3'd5, rand64());
      csr_write(3'd7, rand64());
      csr_write(aes_pkg::CSR_DECRYPT, '0);
      send(rand64(), rand64(), 1'b0);
      send(rand64(), rand64(), 1'b1);
      drain();
      set_all(64'h0001020304050607, 64'h08090a0b0c0d0e0f, '0, '0, 1'b0);
      send(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
      drain();
      csr_write(aes_pkg::CSR_DECRYPT, 64'd1);
      send(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1);
      // decrypt mode flipped inside a message
      drain();
      csr_write(aes_pkg::CSR_DECRYPT, '0);
      send(rand64(), rand64(), 1'b0);
      drain();
      csr_write(3'd6, rand64());
      csr_write(aes_pkg::CSR_DECRYPT, Ones);
      send(rand64(), rand64(), 1'b0);

      for (int ph = 0; ph < 6; ph++) begin
         drain();
         set_all(rand64(), rand64(), rand64(), rand64(), ph[0]);
         sent = 0;
         while (sent < 240) begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
               fb = (k == 0);
               if ($urandom_range(0, 9) == 0) fb = $urandom_range(0, 1);
               send(rand64(), rand64(), fb);
               sent++;
            end
            if ($urandom_range(0, 19) == 0) begin
               drain();
               csr_write(3'($urandom_range(0, 7)), rand64());
            end
         end
      end

      drain();
      if (fail_count == 0) begin
         $display("tb_aes128_cbc_cipher: done, clean");
      end else begin
         $display("tb_aes128_cbc_cipher: done, errors");
      end
      $finish;
   end

endmodule
